// ===== src/tpc_pkg.sv =====
// Package for the three-point path curvature block: widths, payload and operand types.
package tpc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PW   = 32;                 // coordinate / payload field width
    localparam int DW   = PW + 1;             // coordinate difference width
    localparam int SQW  = 2 * DW;             // squared distance / cross magnitude
    localparam int MPW  = SQW;                // multiplier operand width
    localparam int NSH  = 2 + 4 * FRAC_BITS;  // numerator scale shift
    localparam int NUMW = 2 * SQW + NSH;      // scaled numerator width
    localparam int DENW = 3 * SQW;            // denominator width
    localparam int QW   = 64;                 // clipped quotient width
    localparam int RTW  = 32;                 // root / curvature width
    localparam int SRW  = RTW + 2;            // root remainder width
    localparam int WA   = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;
    localparam int CNTW = $clog2(((MPW > QW) ? MPW : QW) + 1);

    typedef struct packed {
        logic signed [PW-1:0] point_x;
        logic signed [PW-1:0] point_y;
        logic signed [PW-1:0] point_extra;
    } t_pt_in;

    typedef struct packed {
        logic signed [PW-1:0] mid_x;
        logic signed [PW-1:0] mid_y;
        logic signed [PW-1:0] mid_extra;
        logic [RTW-1:0]       path_curvature;
    } t_pt_out;

    // coordinate differences of one window
    typedef struct packed {
        logic signed [DW-1:0] dx1;  // b - a
        logic signed [DW-1:0] dy1;
        logic signed [DW-1:0] dx2;  // c - b
        logic signed [DW-1:0] dy2;
        logic signed [DW-1:0] ex;   // c - a
        logic signed [DW-1:0] ey;
    } t_diff;

endpackage

// ===== src/tpc_engine.sv =====
// Sequenced curvature engine: shift-add multiplies, restoring divide and root on one adder.
module tpc_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tpc_pkg::t_diff        i_diff,
    input  logic                  i_take,
    output logic                  o_idle,
    output logic                  o_done,
    output logic [tpc_pkg::RTW-1:0] o_curv
);
    import tpc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_STORE = 8'b0000_1000,
        S_CHK   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // multiply steps, in program order
    typedef enum logic [3:0] {
        M_CP, M_CQ, M_AX, M_AY, M_BX, M_BY, M_CX, M_CY, M_SQ, M_D1, M_D2
    } t_mop;

    t_state r_state;
    t_mop   r_op;
    t_diff  r_diff;

    logic [WA-1:0]     r_acc, r_mcand, r_rem, r_dsh;
    logic [MPW-1:0]    r_mplier;
    logic              r_sub;
    logic [CNTW-1:0]   r_cnt;
    logic [SQW-1:0]    r_cross, r_dab, r_dbc, r_dac;
    logic [2*SQW-1:0]  r_num;
    logic [QW-1:0]     r_quo;
    logic [SRW-1:0]    r_sqr;
    logic [RTW-1:0]    r_root, r_k;

    // operand magnitudes
    logic [DW-1:0] m_dx1, m_dy1, m_dx2, m_dy2, m_ex, m_ey;
    logic          w_pn, w_qn;

    function automatic logic [DW-1:0] f_mag(input logic signed [DW-1:0] d);
        return d[DW-1] ? DW'(~d + 1'b1) : DW'(d);
    endfunction

    assign m_dx1 = f_mag(r_diff.dx1);
    assign m_dy1 = f_mag(r_diff.dy1);
    assign m_dx2 = f_mag(r_diff.dx2);
    assign m_dy2 = f_mag(r_diff.dy2);
    assign m_ex  = f_mag(r_diff.ex);
    assign m_ey  = f_mag(r_diff.ey);
    assign w_pn  = r_diff.dx1[DW-1] ^ r_diff.dy2[DW-1];
    assign w_qn  = r_diff.dy1[DW-1] ^ r_diff.dx2[DW-1];

    // operand select for the step being loaded
    t_mop            w_ld;
    logic [WA-1:0]   ld_mcand;
    logic [MPW-1:0]  ld_mplier;
    logic            ld_sub, ld_clr;
    logic [CNTW-1:0] ld_steps;

    assign w_ld = (r_state == S_LOAD) ? r_op : t_mop'(r_op + 1'b1);

    always_comb begin
        ld_mcand  = '0;
        ld_mplier = '0;
        ld_sub    = 1'b0;
        ld_clr    = 1'b1;
        ld_steps  = CNTW'(DW);
        unique case (w_ld)
            M_CP: begin
                ld_mcand  = WA'(m_dx1);
                ld_mplier = MPW'(m_dy2);
                ld_sub    = w_pn;
            end
            M_CQ: begin
                ld_mcand  = WA'(m_dy1);
                ld_mplier = MPW'(m_dx2);
                ld_sub    = ~w_qn;
                ld_clr    = 1'b0;
            end
            M_AX: begin
                ld_mcand  = WA'(m_dx1);
                ld_mplier = MPW'(m_dx1);
            end
            M_AY: begin
                ld_mcand  = WA'(m_dy1);
                ld_mplier = MPW'(m_dy1);
                ld_clr    = 1'b0;
            end
            M_BX: begin
                ld_mcand  = WA'(m_dx2);
                ld_mplier = MPW'(m_dx2);
            end
            M_BY: begin
                ld_mcand  = WA'(m_dy2);
                ld_mplier = MPW'(m_dy2);
                ld_clr    = 1'b0;
            end
            M_CX: begin
                ld_mcand  = WA'(m_ex);
                ld_mplier = MPW'(m_ex);
            end
            M_CY: begin
                ld_mcand  = WA'(m_ey);
                ld_mplier = MPW'(m_ey);
                ld_clr    = 1'b0;
            end
            M_SQ: begin
                ld_mcand  = WA'(r_cross);
                ld_mplier = r_cross;
                ld_steps  = CNTW'(MPW);
            end
            M_D1: begin
                ld_mcand  = WA'(r_dab);
                ld_mplier = r_dbc;
                ld_steps  = CNTW'(MPW);
            end
            M_D2: begin
                // partial product still sits in the accumulator
                ld_mcand  = r_acc;
                ld_mplier = r_dac;
                ld_steps  = CNTW'(MPW);
            end
            default: begin
                ld_mcand  = '0;
            end
        endcase
    end

    // the shared adder
    logic [WA-1:0]   a_op, b_op;
    logic            a_sub;
    logic [WA:0]     w_sum;
    logic            w_carry;
    logic [SRW+1:0]  w_rr;

    assign w_rr = {r_sqr, r_quo[QW-1 -: 2]};

    always_comb begin
        a_op  = '0;
        b_op  = '0;
        a_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                a_op  = r_acc;
                b_op  = r_mplier[0] ? r_mcand : '0;
                a_sub = r_sub;
            end
            S_STORE: begin
                // magnitude of the signed cross product
                b_op  = r_acc;
                a_sub = r_acc[WA-1];
            end
            S_CHK, S_DIV: begin
                a_op  = r_rem;
                b_op  = r_dsh;
                a_sub = 1'b1;
            end
            S_SQRT: begin
                a_op  = WA'(w_rr);
                b_op  = WA'({r_root, 2'b01});
                a_sub = 1'b1;
            end
            default: begin
                a_op = '0;
            end
        endcase
    end

    assign w_sum   = {1'b0, a_op} + {1'b0, (a_sub ? ~b_op : b_op)} + (WA+1)'(a_sub);
    assign w_carry = w_sum[WA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= M_CP;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_diff  <= i_diff;
                        r_op    <= M_CP;
                        r_state <= S_LOAD;
                    end
                end
                S_MUL: begin
                    r_acc    <= w_sum[WA-1:0];
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_STORE;
                    end
                end
                S_LOAD, S_STORE: begin
                    r_mcand  <= ld_mcand;
                    r_mplier <= ld_mplier;
                    r_sub    <= ld_sub;
                    r_cnt    <= ld_steps;
                    if (ld_clr) begin
                        r_acc <= '0;
                    end
                    r_op    <= w_ld;
                    r_state <= S_MUL;
                    if (r_state == S_STORE) begin
                        case (r_op)
                            M_CQ: r_cross <= w_sum[SQW-1:0];
                            M_AY: r_dab   <= r_acc[SQW-1:0];
                            M_BY: r_dbc   <= r_acc[SQW-1:0];
                            M_CY: begin
                                r_dac <= r_acc[SQW-1:0];
                                if (r_cross == '0) begin
                                    r_k     <= '0;    // collinear or coinciding
                                    r_state <= S_DONE;
                                end
                            end
                            M_SQ: r_num <= r_acc[2*SQW-1:0];
                            M_D2: begin
                                r_rem   <= WA'(r_num) << NSH;
                                r_dsh   <= r_acc << QW;
                                r_state <= S_CHK;
                            end
                            default: r_num <= r_num;
                        endcase
                    end
                end
                S_CHK: begin
                    if (w_carry) begin
                        r_k     <= '1;        // quotient beyond clip: saturate
                        r_state <= S_DONE;
                    end else begin
                        r_dsh   <= r_dsh >> 1;
                        r_cnt   <= CNTW'(QW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_carry) begin
                        r_rem <= w_sum[WA-1:0];
                    end
                    r_quo <= {r_quo[QW-2:0], w_carry};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_sqr   <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNTW'(RTW);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sqr  <= w_carry ? w_sum[SRW-1:0] : w_rr[SRW-1:0];
                    r_quo  <= r_quo << 2;
                    r_root <= {r_root[RTW-2:0], w_carry};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_k     <= {r_root[RTW-2:0], w_carry};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_curv = r_k;

endmodule

// ===== src/three_point_path_curvature.sv =====
// Top level of the three-point path curvature block: point window and output register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one path point per beat.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives the middle point of
//   the window with the unsigned Menger curvature 2|cross| / (|ab| |bc| |ac|),
//   Q16.16, rounded toward zero and saturated at all ones; 0 for collinear points.
//   The first two points after reset only fill the window and give no beat.
//   From the third point on each input beat yields one output beat.
//   The engine runs shift-add multiplies (33 or 66 steps each), a 64-step restoring
//   divide and a 32-step root on one shared adder; collinear points skip the remaining
//   products, the divide and the root, and a saturating value skips the divide and root.
//   Throughput is one point per engine run; o_in_ready is high only while the
//   engine is idle. Warm-up points only fill the window and do not start the engine.
//   A finished beat waits in the output register; the engine may take the next
//   point meanwhile, and holds its own result until the register frees up.
//   Reset (synchronous, active low) empties the window and drops any pending beat.
module three_point_path_curvature (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tpc_pkg::t_pt_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpc_pkg::t_pt_out   o_out_data
);
    import tpc_pkg::*;

    localparam logic [1:0] SEEN_FULL = 2'd2;

    // window: a = oldest, b = middle
    logic signed [PW-1:0] r_ax, r_ay, r_bx, r_by, r_bextra;
    logic [1:0]           r_seen;

    logic     w_in_acc, w_start, w_idle, w_done, w_take;
    t_diff    w_diff;
    logic [RTW-1:0] w_curv;

    // middle point of the window under computation
    logic signed [PW-1:0] r_px, r_py, r_pextra;

    t_pt_out r_out;
    logic    r_out_valid;

    assign o_in_ready = w_idle;
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_start    = w_in_acc & (r_seen == SEEN_FULL);

    // differences, sign-extended by one bit so they cannot wrap
    assign w_diff.dx1 = DW'(r_bx) - DW'(r_ax);
    assign w_diff.dy1 = DW'(r_by) - DW'(r_ay);
    assign w_diff.dx2 = DW'(i_in_data.point_x) - DW'(r_bx);
    assign w_diff.dy2 = DW'(i_in_data.point_y) - DW'(r_by);
    assign w_diff.ex  = DW'(i_in_data.point_x) - DW'(r_ax);
    assign w_diff.ey  = DW'(i_in_data.point_y) - DW'(r_ay);

    tpc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_diff  (w_diff),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_curv  (w_curv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_in_acc) begin
            if (r_seen != SEEN_FULL) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    // window and pending payload need no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax     <= r_bx;
            r_ay     <= r_by;
            r_bx     <= i_in_data.point_x;
            r_by     <= i_in_data.point_y;
            r_bextra <= i_in_data.point_extra;
        end
        if (w_start) begin
            r_px     <= r_bx;
            r_py     <= r_by;
            r_pextra <= r_bextra;
        end
    end

    // output register: loads when empty or being drained
    assign w_take = w_done & (~r_out_valid | i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.mid_x          <= r_px;
            r_out.mid_y          <= r_py;
            r_out.mid_extra      <= r_pextra;
            r_out.path_curvature <= w_curv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/tpc_checker.sv =====
// Scoreboard for the curvature block: predicts each output beat and compares it.
`timescale 1ns / 100ps

module tpc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  tpc_pkg::t_pt_in   i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  tpc_pkg::t_pt_out  i_out_data,
    output int                o_errors,
    output int                o_pending
);
    import tpc_pkg::*;

    typedef logic [299:0] t_wide;

    t_pt_out   expected_beats[$];
    t_pt_in    win_old;
    t_pt_in    win_mid;
    int        pts_held;

    function automatic t_wide mag80(logic signed [79:0] v);
        return (v < 0) ? t_wide'(-v) : t_wide'(v);
    endfunction

    function automatic t_wide sq_len(longint dx, longint dy);
        t_wide mx;
        t_wide my;
        mx = mag80(dx);
        my = mag80(dy);
        return mx * mx + my * my;
    endfunction

    // exact curvature, rounded toward zero, saturating at all ones
    function automatic logic [RTW-1:0] menger_k(longint ax, longint ay, longint bx,
                                                longint by, longint cx, longint cy);
        logic signed [79:0] dx1;
        logic signed [79:0] dy1;
        logic signed [79:0] dx2;
        logic signed [79:0] dy2;
        t_wide              cr;
        t_wide              num;
        t_wide              den;
        t_wide              trial;
        logic [RTW-1:0]     q;
        logic [RTW-1:0]     t;
        dx1 = bx - ax;
        dy1 = by - ay;
        dx2 = cx - bx;
        dy2 = cy - by;
        cr  = mag80(dx1 * dy2 - dy1 * dx2);
        if (cr == 0) begin
            return '0;
        end
        num = (cr * cr) << NSH;
        den = sq_len(bx - ax, by - ay) * sq_len(cx - bx, cy - by) * sq_len(cx - ax, cy - ay);
        q = '0;
        for (int b = RTW - 1; b >= 0; b--) begin
            t = q | (RTW'(1) << b);
            trial = t_wide'(t) * t_wide'(t) * den;
            if (trial <= num) begin
                q = t;
            end
        end
        return q;
    endfunction

    assign o_pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_pt_out exp_b;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            expected_beats.delete();
            win_old  <= '0;
            win_mid  <= '0;
            pts_held <= 0;
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (pts_held >= 2) begin
                    exp_b.mid_x          = win_mid.point_x;
                    exp_b.mid_y          = win_mid.point_y;
                    exp_b.mid_extra      = win_mid.point_extra;
                    exp_b.path_curvature = menger_k(win_old.point_x, win_old.point_y,
                                                    win_mid.point_x, win_mid.point_y,
                                                    i_in_data.point_x, i_in_data.point_y);
                    expected_beats.push_back(exp_b);
                end
                win_old <= win_mid;
                win_mid <= i_in_data;
                if (pts_held < 2) begin
                    pts_held <= pts_held + 1;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output beat %p", i_out_data);
                    bad = 1;
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (i_out_data.mid_x !== exp_b.mid_x) begin
                        $error("mid_x exp %0d got %0d", exp_b.mid_x, i_out_data.mid_x);
                        bad++;
                    end
                    if (i_out_data.mid_y !== exp_b.mid_y) begin
                        $error("mid_y exp %0d got %0d", exp_b.mid_y, i_out_data.mid_y);
                        bad++;
                    end
                    if (i_out_data.mid_extra !== exp_b.mid_extra) begin
                        $error("mid_extra exp %0d got %0d", exp_b.mid_extra,
                               i_out_data.mid_extra);
                        bad++;
                    end
                    if (i_out_data.path_curvature !== exp_b.path_curvature) begin
                        $error("path_curvature exp %h got %h", exp_b.path_curvature,
                               i_out_data.path_curvature);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the curvature testbench: clock, reset, point stimulus, output stalls, verdict.
`timescale 1ns / 100ps

module testbench;
    import tpc_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;  // hard stop, well above what ~700 points need
    localparam int DRAIN_WAIT  = 700;        // one full engine run

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    logic     in_ready;
    t_pt_in   in_beat;
    logic     out_valid;
    logic     out_ready;
    t_pt_out  out_beat;
    int       err_count;
    int       pending_cnt;
    int       cycle_cnt;
    bit       calm_phase;   // no idling while set

    three_point_path_curvature u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    tpc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_beat),
        .o_errors    (err_count),
        .o_pending   (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop on a hung block
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm_phase ? 0 : $urandom_range(0, 6);
    endfunction

    // one input beat; valid stays up until the block takes the point
    task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] e);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{point_x: x, point_y: y, point_extra: e};
        do @(posedge i_clk); while (!in_ready);
    endtask

    // output side: random stall before each beat, then ready until taken
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] sx;
        logic [31:0] sy;
        int          kind;
        int          len;
        cycle_cnt  = 0;
        calm_phase = 1'b0;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_beat    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: warm-up, coincident, collinear, tiny triangle (saturates),
        // coordinate extremes, a unit-ish circle
        push_point(32'h0, 32'h0, 32'h1111_1111);
        push_point(32'h0, 32'h0, 32'h8000_0000);
        push_point(32'h0, 32'h0, 32'h7FFF_FFFF);              // all coincide
        push_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        push_point(32'h0002_0000, 32'h0002_0000, 32'h0);      // collinear
        push_point(32'h0002_0001, 32'h0002_0000, 32'h5);
        push_point(32'h0002_0000, 32'h0002_0001, 32'h6);      // tiny -> saturate
        push_point(32'h8000_0000, 32'h8000_0000, 32'h7);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h9);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hA);
        push_point(32'h0001_0000, 32'h0, 32'hB);              // circle radius 1 m
        push_point(32'h0, 32'h0001_0000, 32'hC);
        push_point(32'hFFFF_0000, 32'h0, 32'hD);
        push_point(32'h0, 32'hFFFF_0000, 32'hE);
        push_point(32'h0001_0000, 32'h0, 32'hF);              // back on itself
        push_point(32'h0, 32'h0, 32'h10);

        // random: mostly smooth paths, some collinear runs, some wild points
        bx = 0;
        by = 0;
        for (int n = 0; n < 700; n++) begin
            if (n % 100 == 0) begin
                calm_phase = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                len = $urandom_range(4, 20);
                sx  = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                sy  = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                for (int j = 0; j < len; j++) begin
                    sx = sx + $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
                    sy = sy + $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
                    bx = bx + sx;
                    by = by + sy;
                    push_point(bx, by, $urandom());
                end
                n = n + len - 1;
            end else if (kind < 7) begin
                sx = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                sy = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                for (int j = 0; j < 3; j++) begin
                    bx = bx + sx;
                    by = by + sy;
                    push_point(bx, by, $urandom());
                end
                n = n + 2;
            end else if (kind < 8) begin
                push_point(bx, by, $urandom());                // repeat last point
            end else begin
                bx = $urandom();
                by = $urandom();
                push_point(bx, by, $urandom());
            end
        end
        in_valid <= 1'b0;

        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tpc_pkg.sv
src/tpc_engine.sv
src/three_point_path_curvature.sv
tb/tpc_checker.sv
tb/testbench.sv
